FILE: hdl/hbp_pkg.sv
// Shared types and constants of the hybrid branch predictor.
package hbp_pkg;

  // One resolved branch as it enters the predictor.
  typedef struct packed {
    logic [31:0] branch_pc;
    logic        taken;
  } in_t;

  // One prediction report.
  typedef struct packed {
    logic predicted_taken;
    logic used_gshare;
    logic gshare_guess;
    logic bimodal_guess;
    logic mispredicted;
  } out_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CHOOSER_BITS = 2'd0,
    CFG_GSHARE_BITS  = 2'd1,
    CFG_HISTORY_BITS = 2'd2,
    CFG_BIMODAL_BITS = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 5;

  localparam logic [3:0] ChooserBitsReset = 4'd8;
  localparam logic [4:0] GshareBitsReset  = 5'd12;
  localparam logic [4:0] HistoryBitsReset = 5'd8;
  localparam logic [4:0] BimodalBitsReset = 5'd12;

  localparam logic [2:0] CtrReset     = 3'd4;
  localparam logic [2:0] CtrMax       = 3'd7;
  localparam logic [1:0] ChooserReset = 2'd1;
  localparam logic [1:0] ChooserMax   = 2'd3;

endpackage

FILE: hdl/hbp_fifo.sv
// Small first-in first-out queue held in flip-flops.
module hbp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/hbp_front.sv
// Front end: configuration, global history and table index generation.
module hbp_front #(
  parameter int unsigned CMAX = 12,
  parameter int unsigned GMAX = 16,
  parameter int unsigned BMAX = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hbp_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [hbp_pkg::CfgDataWidth-1:0]     cfg_data_i,
  input  logic                                 accept_i,
  input  hbp_pkg::in_t                         in_i,
  output logic [CMAX-1:0]                      ci_o,
  output logic [GMAX-1:0]                      gi_o,
  output logic [BMAX-1:0]                      bi_o,
  output logic                                 taken_o
);

  localparam int unsigned CW = $clog2(CMAX + 1);
  localparam int unsigned GW = $clog2(GMAX + 1);
  localparam int unsigned BW = $clog2(BMAX + 1);

  logic [3:0]      chooser_bits_q;
  logic [4:0]      gshare_bits_q, history_bits_q, bimodal_bits_q;
  logic [GMAX-1:0] hist_q, hist_d;

  logic [CW-1:0]   c_eff;
  logic [GW-1:0]   g_eff, h_eff;
  logic [BW-1:0]   b_eff;
  logic [CMAX-1:0] cmask;
  logic [GMAX-1:0] gmask, hmask, hist, top;
  logic [BMAX-1:0] bmask;
  logic [29:0]     word;

  // Clamp each configured width to what the tables can hold; history to the gshare width.
  always_comb begin
    c_eff = (int'(chooser_bits_q) > int'(CMAX)) ? CW'(CMAX) : CW'(chooser_bits_q);
    g_eff = (int'(gshare_bits_q) > int'(GMAX)) ? GW'(GMAX) : GW'(gshare_bits_q);
    b_eff = (int'(bimodal_bits_q) > int'(BMAX)) ? BW'(BMAX) : BW'(bimodal_bits_q);
    h_eff = (int'(history_bits_q) > int'(g_eff)) ? g_eff : GW'(history_bits_q);
    for (int i = 0; i < int'(CMAX); i++) cmask[i] = (i < int'(c_eff));
    for (int i = 0; i < int'(GMAX); i++) gmask[i] = (i < int'(g_eff));
    for (int i = 0; i < int'(GMAX); i++) hmask[i] = (i < int'(h_eff));
    for (int i = 0; i < int'(BMAX); i++) bmask[i] = (i < int'(b_eff));
  end

  assign word = in_i.branch_pc[31:2];
  assign hist = hist_q & hmask;
  assign ci_o = word[CMAX-1:0] & cmask;
  assign gi_o = (word[GMAX-1:0] & gmask) ^ hist;
  assign bi_o = word[BMAX-1:0] & bmask;
  assign taken_o = in_i.taken;

  // Top history bit is the highest set bit of the history mask.
  assign top = in_i.taken ? (hmask & ~(hmask >> 1)) : '0;

  always_comb begin
    hist_d = hist_q;
    if (accept_i && (h_eff != '0)) begin
      hist_d = ((hist >> 1) | top) & hmask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chooser_bits_q <= hbp_pkg::ChooserBitsReset;
      gshare_bits_q  <= hbp_pkg::GshareBitsReset;
      history_bits_q <= hbp_pkg::HistoryBitsReset;
      bimodal_bits_q <= hbp_pkg::BimodalBitsReset;
      hist_q         <= '0;
    end else begin
      hist_q <= hist_d;
      if (cfg_we_i) begin
        case (hbp_pkg::cfg_idx_e'(cfg_idx_i))
          hbp_pkg::CFG_CHOOSER_BITS: chooser_bits_q <= cfg_data_i[3:0];
          hbp_pkg::CFG_GSHARE_BITS:  gshare_bits_q  <= cfg_data_i;
          hbp_pkg::CFG_HISTORY_BITS: history_bits_q <= cfg_data_i;
          hbp_pkg::CFG_BIMODAL_BITS: bimodal_bits_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: hdl/hbp_back.sv
// Back end: counter tables, clearing pass, prediction and training.
module hbp_back #(
  parameter int unsigned CMAX = 12,
  parameter int unsigned GMAX = 16,
  parameter int unsigned BMAX = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  logic [CMAX-1:0] head_ci_i,
  input  logic [GMAX-1:0] head_gi_i,
  input  logic [BMAX-1:0] head_bi_i,
  input  logic            head_taken_i,
  output logic            head_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output hbp_pkg::out_t   res_o,
  output logic            busy_o
);

  localparam int unsigned MaxGB = (GMAX > BMAX) ? GMAX : BMAX;
  localparam int unsigned ClrW  = (MaxGB > CMAX) ? MaxGB : CMAX;

  logic [1:0] cho_mem [2**CMAX];
  logic [2:0] gsh_mem [2**GMAX];
  logic [2:0] bim_mem [2**BMAX];

  logic            busy_q;
  logic [ClrW-1:0] clr_addr_q;

  logic            s2_valid_q;
  logic [CMAX-1:0] s2_ci_q;
  logic [GMAX-1:0] s2_gi_q;
  logic [BMAX-1:0] s2_bi_q;
  logic            s2_taken_q;
  logic [1:0]      cho_rd_q, cho_fwd_q;
  logic [2:0]      gsh_rd_q, gsh_fwd_q, bim_rd_q, bim_fwd_q;
  logic            cho_hit_q, gsh_hit_q, bim_hit_q;

  logic            retire, rd_fire;
  logic [1:0]      cho, cho_new;
  logic [2:0]      gsh, bim;
  logic            gsh_guess, bim_guess, use_gsh, pred;

  logic            cho_we, gsh_we, bim_we;
  logic [CMAX-1:0] cho_wa;
  logic [GMAX-1:0] gsh_wa;
  logic [BMAX-1:0] bim_wa;
  logic [1:0]      cho_wd;
  logic [2:0]      gsh_wd, bim_wd;

  function automatic logic [2:0] bump3(logic [2:0] ctr, logic up);
    if (up) begin
      return (ctr < hbp_pkg::CtrMax) ? ctr + 3'd1 : ctr;
    end
    return (ctr > 3'd0) ? ctr - 3'd1 : ctr;
  endfunction

  assign retire     = s2_valid_q && !res_full_i;
  assign rd_fire    = head_valid_i && !busy_q && (!s2_valid_q || retire);
  assign head_pop_o = rd_fire;
  assign busy_o     = busy_q;

  // Take the value written at the read edge over the stale memory read.
  assign cho = cho_hit_q ? cho_fwd_q : cho_rd_q;
  assign gsh = gsh_hit_q ? gsh_fwd_q : gsh_rd_q;
  assign bim = bim_hit_q ? bim_fwd_q : bim_rd_q;

  assign gsh_guess = gsh[2];
  assign bim_guess = bim[2];
  assign use_gsh   = cho[1];
  assign pred      = use_gsh ? gsh_guess : bim_guess;

  always_comb begin
    cho_new = cho;
    if ((gsh_guess == s2_taken_q) && (bim_guess != s2_taken_q)) begin
      if (cho < hbp_pkg::ChooserMax) cho_new = cho + 2'd1;
    end else if ((gsh_guess != s2_taken_q) && (bim_guess == s2_taken_q)) begin
      if (cho > 2'd0) cho_new = cho - 2'd1;
    end
  end

  always_comb begin
    if (busy_q) begin
      cho_we = 1'b1;
      gsh_we = 1'b1;
      bim_we = 1'b1;
      cho_wa = clr_addr_q[CMAX-1:0];
      gsh_wa = clr_addr_q[GMAX-1:0];
      bim_wa = clr_addr_q[BMAX-1:0];
      cho_wd = hbp_pkg::ChooserReset;
      gsh_wd = hbp_pkg::CtrReset;
      bim_wd = hbp_pkg::CtrReset;
    end else begin
      cho_we = retire;
      gsh_we = retire && use_gsh;
      bim_we = retire && !use_gsh;
      cho_wa = s2_ci_q;
      gsh_wa = s2_gi_q;
      bim_wa = s2_bi_q;
      cho_wd = cho_new;
      gsh_wd = bump3(gsh, s2_taken_q);
      bim_wd = bump3(bim, s2_taken_q);
    end
  end

  assign res_push_o            = retire;
  assign res_o.predicted_taken = pred;
  assign res_o.used_gshare     = use_gsh;
  assign res_o.gshare_guess    = gsh_guess;
  assign res_o.bimodal_guess   = bim_guess;
  assign res_o.mispredicted    = pred != s2_taken_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      if (busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == '1) busy_q <= 1'b0;
      end
      if (rd_fire) begin
        s2_valid_q <= 1'b1;
      end else if (retire) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      s2_ci_q    <= head_ci_i;
      s2_gi_q    <= head_gi_i;
      s2_bi_q    <= head_bi_i;
      s2_taken_q <= head_taken_i;
      cho_hit_q  <= cho_we && (cho_wa == head_ci_i);
      gsh_hit_q  <= gsh_we && (gsh_wa == head_gi_i);
      bim_hit_q  <= bim_we && (bim_wa == head_bi_i);
      cho_fwd_q  <= cho_wd;
      gsh_fwd_q  <= gsh_wd;
      bim_fwd_q  <= bim_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cho_we) cho_mem[cho_wa] <= cho_wd;
    if (rd_fire) cho_rd_q <= cho_mem[head_ci_i];
  end

  always_ff @(posedge clk_i) begin
    if (gsh_we) gsh_mem[gsh_wa] <= gsh_wd;
    if (rd_fire) gsh_rd_q <= gsh_mem[head_gi_i];
  end

  always_ff @(posedge clk_i) begin
    if (bim_we) bim_mem[bim_wa] <= bim_wd;
    if (rd_fire) bim_rd_q <= bim_mem[head_bi_i];
  end

endmodule

FILE: hdl/hybrid_branch_predictor.sv
// Path: index queue, back-end read registers, result queue, then empty goes low.
// Throughput: one branch per cycle while not clearing and the result queue has room;
// each branch reads every table but writes only the chooser and its chosen counter.
// Reset: config 8/12/8/12, history 0; then clearing 2**(largest *_MAX_BITS) addresses
// (65536 by default) loads all counters; full stays high during it, config writes land.
module hybrid_branch_predictor #(
  parameter int unsigned CHOOSER_MAX_BITS = 12,
  parameter int unsigned GSHARE_MAX_BITS  = 16,
  parameter int unsigned BIMODAL_MAX_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hbp_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [hbp_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  hbp_pkg::in_t                     in_data_i,
  input  logic                             pop,
  output logic                             empty,
  output hbp_pkg::out_t                    out_data_o
);

  localparam int unsigned CMAX = CHOOSER_MAX_BITS;
  localparam int unsigned GMAX = GSHARE_MAX_BITS;
  localparam int unsigned BMAX = BIMODAL_MAX_BITS;
  localparam int unsigned QW   = CMAX + GMAX + BMAX + 1;

  logic            accept;
  logic [CMAX-1:0] f_ci, h_ci;
  logic [GMAX-1:0] f_gi, h_gi;
  logic [BMAX-1:0] f_bi, h_bi;
  logic            f_taken, h_taken;
  logic [QW-1:0]   q_in, q_out;
  logic            q_full, q_empty, q_pop;
  logic            busy;
  logic            res_push, res_full;
  hbp_pkg::out_t   res;

  // Hold off new branches while the tables are cleared or the index queue fills.
  assign full   = q_full || busy;
  assign accept = push && !full;

  // Front: derive the three table indexes and advance the global history.
  hbp_front #(
    .CMAX(CMAX),
    .GMAX(GMAX),
    .BMAX(BMAX)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .accept_i  (accept),
    .in_i      (in_data_i),
    .ci_o      (f_ci),
    .gi_o      (f_gi),
    .bi_o      (f_bi),
    .taken_o   (f_taken)
  );

  // Decouple front and back so each can stall independently.
  assign q_in = {f_ci, f_gi, f_bi, f_taken};
  assign {h_ci, h_gi, h_bi, h_taken} = q_out;

  hbp_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_idx_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_out),
    .empty_o(q_empty)
  );

  // Back: read counters, form the report, train the chosen counter and chooser.
  hbp_back #(
    .CMAX(CMAX),
    .GMAX(GMAX),
    .BMAX(BMAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(!q_empty),
    .head_ci_i   (h_ci),
    .head_gi_i   (h_gi),
    .head_bi_i   (h_bi),
    .head_taken_i(h_taken),
    .head_pop_o  (q_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res),
    .busy_o      (busy)
  );

  // Output register stage: keeps the back end moving while a report waits.
  hbp_fifo #(
    .WIDTH($bits(hbp_pkg::out_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_data_o),
    .empty_o(empty)
  );

  // No report may appear while the clearing pass is running.
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> empty)
    else $error("report visible during table clearing");

  // The back end never draws from the index queue while clearing.
  a_no_issue_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !q_pop)
    else $error("index queue popped during table clearing");

  // The final guess follows the component the chooser selected.
  a_pred_follows_choice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.predicted_taken == (out_data_o.used_gshare ?
      out_data_o.gshare_guess : out_data_o.bimodal_guess)))
    else $error("final prediction does not match the selected component");

endmodule

FILE: sim/hybrid_branch_predictor_test.sv
// Self-checking testbench of the hybrid branch predictor, with its own tournament model.
module hybrid_branch_predictor_test;

  localparam int unsigned CHOOSER_MAX_BITS = 12;
  localparam int unsigned GSHARE_MAX_BITS  = 16;
  localparam int unsigned BIMODAL_MAX_BITS = 16;
  // Longest quiet stretch: the clearing pass after reset plus the long hold-off.
  localparam int unsigned QUIET_LIMIT      = 300000;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned HOT_BRANCHES     = 16;

  typedef enum int unsigned {
    ALWAYS_TAKEN,
    NEVER_TAKEN,
    LOOP_EXIT,
    COIN_FLIP
  } branch_habit_e;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [hbp_pkg::CfgIdxWidth-1:0]  cfg_idx_i;
  logic [hbp_pkg::CfgDataWidth-1:0] cfg_data_i;
  logic                             push;
  logic                             full;
  hbp_pkg::in_t                     in_data_i;
  logic                             pop;
  logic                             empty;
  hbp_pkg::out_t                    out_data_o;

  hybrid_branch_predictor #(
    .CHOOSER_MAX_BITS(CHOOSER_MAX_BITS),
    .GSHARE_MAX_BITS (GSHARE_MAX_BITS),
    .BIMODAL_MAX_BITS(BIMODAL_MAX_BITS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .push      (push),
    .full      (full),
    .in_data_i (in_data_i),
    .pop       (pop),
    .empty     (empty),
    .out_data_o(out_data_o)
  );

  // Predictor state mirrored on the testbench side.
  logic [1:0]  chooser_ctr [1 << CHOOSER_MAX_BITS];
  logic [2:0]  gshare_ctr  [1 << GSHARE_MAX_BITS];
  logic [2:0]  bimodal_ctr [1 << BIMODAL_MAX_BITS];
  logic [15:0] path_history;
  logic [3:0]  chooser_bits;
  logic [4:0]  gshare_bits;
  logic [4:0]  history_bits;
  logic [4:0]  bimodal_bits;

  hbp_pkg::out_t pending_reports [$];
  int unsigned   error_count;
  int unsigned   send_idle_pct;
  int unsigned   stall_pct;
  int unsigned   hold_off_cycles;

  // Hot branches give the tables something to learn.
  logic [31:0]   hot_pc    [HOT_BRANCHES];
  branch_habit_e hot_habit [HOT_BRANCHES];
  int unsigned   hot_trip  [HOT_BRANCHES];
  int unsigned   hot_count [HOT_BRANCHES];
  int unsigned   hot_cursor;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned cap_width(int unsigned n, int unsigned max_n);
    return (n > max_n) ? max_n : n;
  endfunction

  function automatic logic [31:0] width_mask(int unsigned n);
    return (32'd1 << n) - 32'd1;
  endfunction

  function automatic logic [2:0] bump_ctr(logic [2:0] ctr, logic up);
    if (up) return (ctr == hbp_pkg::CtrMax) ? ctr : ctr + 3'd1;
    return (ctr == 3'd0) ? ctr : ctr - 3'd1;
  endfunction

  // Predict one resolved branch, then train the mirrored tables.
  function automatic hbp_pkg::out_t resolve_branch(hbp_pkg::in_t br);
    int unsigned                 c, g, h, b;
    logic [31:0]                 word, hmask, hist, bi, gi, ci;
    logic [BIMODAL_MAX_BITS-1:0] bx;
    logic [GSHARE_MAX_BITS-1:0]  gx;
    logic [CHOOSER_MAX_BITS-1:0] cx;
    logic                        bim, gsh, use_g;
    hbp_pkg::out_t               rep;
    c = cap_width(chooser_bits, CHOOSER_MAX_BITS);
    g = cap_width(gshare_bits, GSHARE_MAX_BITS);
    b = cap_width(bimodal_bits, BIMODAL_MAX_BITS);
    h = cap_width(history_bits, g);
    word  = {2'b00, br.branch_pc[31:2]};
    hmask = width_mask(h);
    hist  = {16'd0, path_history} & hmask;
    bi = word & width_mask(b);
    gi = (word & width_mask(g)) ^ hist;
    ci = word & width_mask(c);
    bx = bi[BIMODAL_MAX_BITS-1:0];
    gx = gi[GSHARE_MAX_BITS-1:0];
    cx = ci[CHOOSER_MAX_BITS-1:0];
    // Top bit of a 3-bit counter means 4 or more; of the chooser, 2 or more.
    bim   = bimodal_ctr[bx][2];
    gsh   = gshare_ctr[gx][2];
    use_g = chooser_ctr[cx][1];
    if (use_g) gshare_ctr[gx] = bump_ctr(gshare_ctr[gx], br.taken);
    else bimodal_ctr[bx] = bump_ctr(bimodal_ctr[bx], br.taken);
    if (h != 0) begin
      path_history = 16'(((hist >> 1) | (br.taken ? (32'd1 << (h - 1)) : 32'd0)) & hmask);
    end
    if (gsh == br.taken && bim != br.taken) begin
      if (chooser_ctr[cx] != hbp_pkg::ChooserMax) chooser_ctr[cx] = chooser_ctr[cx] + 2'd1;
    end else if (gsh != br.taken && bim == br.taken) begin
      if (chooser_ctr[cx] != 2'd0) chooser_ctr[cx] = chooser_ctr[cx] - 2'd1;
    end
    rep.predicted_taken = use_g ? gsh : bim;
    rep.used_gshare     = use_g;
    rep.gshare_guess    = gsh;
    rep.bimodal_guess   = bim;
    rep.mispredicted    = rep.predicted_taken != br.taken;
    return rep;
  endfunction

  function automatic void check_bit(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      error_count++;
    end
  endfunction

  task automatic write_reg(hbp_pkg::cfg_idx_e idx, logic [4:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      hbp_pkg::CFG_CHOOSER_BITS: chooser_bits = value[3:0];
      hbp_pkg::CFG_GSHARE_BITS:  gshare_bits  = value;
      hbp_pkg::CFG_HISTORY_BITS: history_bits = value;
      hbp_pkg::CFG_BIMODAL_BITS: bimodal_bits = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [4:0] c, logic [4:0] g, logic [4:0] h, logic [4:0] b);
    write_reg(hbp_pkg::CFG_CHOOSER_BITS, c);
    write_reg(hbp_pkg::CFG_GSHARE_BITS, g);
    write_reg(hbp_pkg::CFG_HISTORY_BITS, h);
    write_reg(hbp_pkg::CFG_BIMODAL_BITS, b);
  endtask

  // Offer one branch, hold it until the transfer, and queue its report.
  task automatic send_branch(logic [31:0] pc, logic taken);
    hbp_pkg::in_t  br;
    hbp_pkg::out_t rep;
    br.branch_pc = pc;
    br.taken     = taken;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_data_i <= br;
    do @(posedge clk_i); while (full);
    rep = resolve_branch(br);
    pending_reports.insert(pending_reports.size(), rep);
  endtask

  // Mostly walk the hot branches in order so history patterns repeat.
  task automatic send_hot_branch();
    int unsigned k;
    logic        taken;
    if ($urandom_range(99) < 15) begin
      send_branch($urandom, 1'($urandom_range(1)));
      return;
    end
    if ($urandom_range(99) < 70) k = (hot_cursor + 1) % HOT_BRANCHES;
    else k = $urandom_range(HOT_BRANCHES - 1);
    hot_cursor = k;
    case (hot_habit[k])
      ALWAYS_TAKEN: taken = $urandom_range(99) >= 3;
      NEVER_TAKEN:  taken = $urandom_range(99) < 3;
      LOOP_EXIT: begin
        hot_count[k]++;
        taken = hot_count[k] < hot_trip[k];
        if (!taken) hot_count[k] = 0;
      end
      default: taken = 1'($urandom_range(1));
    endcase
    send_branch(hot_pc[k], taken);
  endtask

  // Drop push and wait until every report has come back.
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'hFFFF_FFFC, 1'b0);
    send_branch(32'h0000_0003, 1'b1);
    // Saturate one branch high, then walk it down to zero.
    repeat (8) send_branch(32'h0000_1000, 1'b1);
    repeat (8) send_branch(32'h0000_1000, 1'b0);
    repeat (2) begin
      send_branch(32'h0000_1000, 1'b1);
      send_branch(32'h0000_1000, 1'b0);
    end
    drain();
  endtask

  task automatic test_config_corners();
    int unsigned s;
    for (s = 0; s < 6; s++) begin
      case (s)
        0: write_all(5'd0, 5'd0, 5'd0, 5'd0);       // single-entry tables, no history
        1: write_all(5'd31, 5'd31, 5'd31, 5'd31);   // above max: widths saturate
        2: write_all(5'd12, 5'd16, 5'd16, 5'd16);   // exactly at max
        3: write_all(5'd5, 5'd4, 5'd10, 5'd3);      // history longer than gshare index
        4: write_all(5'd1, 5'd1, 5'd1, 5'd1);
        default: write_all(5'd8, 5'd12, 5'd8, 5'd12);
      endcase
      repeat (8) send_hot_branch();
      drain();
    end
  endtask

  // Stall the result side long enough for the input side to back up.
  task automatic test_backpressure();
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_off_cycles = 300;
    repeat (60) send_hot_branch();
    drain();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      write_all(5'($urandom_range(31)), 5'($urandom_range(31)),
                5'($urandom_range(31)), 5'($urandom_range(31)));
      repeat (115) send_hot_branch();
      drain();
    end
  endtask

  // Result side: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= $urandom_range(99) >= stall_pct;
    end
  end

  always @(posedge clk_i) begin
    hbp_pkg::out_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_reports.size() == 0) begin
        $error("report %p with no branch pending", out_data_o);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_bit("predicted_taken", want.predicted_taken, out_data_o.predicted_taken);
        check_bit("used_gshare", want.used_gshare, out_data_o.used_gshare);
        check_bit("gshare_guess", want.gshare_guess, out_data_o.gshare_guess);
        check_bit("bimodal_guess", want.bimodal_guess, out_data_o.bimodal_guess);
        check_bit("mispredicted", want.mispredicted, out_data_o.mispredicted);
      end
    end
  end

  // Watchdog: end the run after too long without any transfer.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned i;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = hbp_pkg::CFG_CHOOSER_BITS;
    cfg_data_i      = '0;
    push            = 1'b0;
    pop             = 1'b0;
    in_data_i       = '0;
    error_count     = 0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_off_cycles = 0;
    hot_cursor      = 0;
    for (i = 0; i < (1 << CHOOSER_MAX_BITS); i++) chooser_ctr[i] = hbp_pkg::ChooserReset;
    for (i = 0; i < (1 << GSHARE_MAX_BITS); i++) gshare_ctr[i] = hbp_pkg::CtrReset;
    for (i = 0; i < (1 << BIMODAL_MAX_BITS); i++) bimodal_ctr[i] = hbp_pkg::CtrReset;
    path_history = '0;
    chooser_bits = hbp_pkg::ChooserBitsReset;
    gshare_bits  = hbp_pkg::GshareBitsReset;
    history_bits = hbp_pkg::HistoryBitsReset;
    bimodal_bits = hbp_pkg::BimodalBitsReset;
    for (i = 0; i < HOT_BRANCHES; i++) begin
      hot_pc[i]    = $urandom;
      hot_habit[i] = branch_habit_e'(i % 4);
      hot_trip[i]  = $urandom_range(6, 2);
      hot_count[i] = 0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_config_corners();
    test_backpressure();
    test_random_traffic();

    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/hbp_pkg.sv
hdl/hbp_fifo.sv
hdl/hbp_front.sv
hdl/hbp_back.sv
hdl/hybrid_branch_predictor.sv
sim/hybrid_branch_predictor_test.sv
